### hw/rtl/trs_pkg.sv
// ----------------------------------------------------------------------------
// Text run splitter package
// Shared widths, character codes, result kinds and the result record type.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int CHAR_W       = 16;
    localparam int REP_W        = 16;
    localparam int LEN_BITS_DEF = 16;
    localparam int RES_SLOTS    = 3;

    localparam logic [CHAR_W-1:0] CH_NBSP    = 16'd160;
    localparam logic [CHAR_W-1:0] MAX_NARROW = 16'd127;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 16'd32;
    localparam logic [CHAR_W-1:0] CH_TAB     = 16'd9;
    localparam logic [CHAR_W-1:0] CH_LF      = 16'd10;
    localparam logic [REP_W-1:0]  REP_MAX    = 16'hFFFF;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] ch;
        logic [REP_W-1:0]  text_len;
        logic [REP_W-1:0]  content_len;
        logic              is_space;
        logic              wide;
        logic              last;
    } t_res;

endpackage

### hw/rtl/text_run_splitter_top.sv
// ----------------------------------------------------------------------------
// Text run splitter
// Splits a stream of 16-bit code units into word or preformatted runs and
// emits transformed characters and run end reports.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_stall    i_char_code, i_flush
// output   out        o_valid / i_stall    o_out_kind .. o_last (one result)
// config   in         i_cfg_we             i_cfg_data (keep_whitespace)
//
// An item is evaluated in the cycle it is accepted; its results (up to three)
// sit in a three-entry result register and leave one per cycle unless stalled.
// An item with one result is taken every cycle unless the output stalls; an item
// with more results holds the input until only one of them is left waiting.
// Reset is synchronous and clears run state, mode and the result count.
// Output stall holds the head result; input stalls while it is held or two or more wait.
// ----------------------------------------------------------------------------
module text_run_splitter_top #(
    parameter int LEN_BITS = trs_pkg::LEN_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [trs_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_flush,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_out_kind,
    output logic [trs_pkg::CHAR_W-1:0] o_out_char,
    output logic [trs_pkg::REP_W-1:0]  o_run_text_len,
    output logic [trs_pkg::REP_W-1:0]  o_run_content_len,
    output logic                       o_run_is_space,
    output logic                       o_wide_seen,
    output logic                       o_last
);
    import trs_pkg::*;

    localparam int EXT_W = (LEN_BITS > REP_W) ? LEN_BITS : REP_W;
    localparam logic [LEN_BITS-1:0] CNT_MAX = {LEN_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] CNT_ONE = LEN_BITS'(1);

    logic                r_keep_ws;
    logic                r_open,  n_open;
    logic                r_space, n_space;
    logic [LEN_BITS-1:0] r_text,  n_text;
    logic [LEN_BITS-1:0] r_cont,  n_cont;
    logic                r_wide,  n_wide;
    logic [1:0]          r_cnt,   n_cnt;
    t_res                r_res [RES_SLOTS];
    t_res                n_res [RES_SLOTS];

    logic                accept, take, load;
    logic                has_a, has_b, has_c;
    t_res                res_a, res_b, res_c;
    logic [CHAR_W-1:0]   emit_ch;
    logic [1:0]          new_cnt;
    t_res                list [RES_SLOTS];
    logic                ws, nbsp, is_tab, is_lf, a_space;
    logic [LEN_BITS-1:0] text_inc, cont_inc;
    logic [EXT_W-1:0]    text_ext, cont_ext;
    logic [REP_W-1:0]    text_rep, cont_rep;
    logic [LEN_BITS-1:0] c_zero;

    assign o_valid = (r_cnt != 2'd0);
    assign take    = o_valid && !i_stall;
    assign o_stall = (r_cnt > 2'd1) || ((r_cnt == 2'd1) && i_stall);
    assign accept  = i_valid && !o_stall;

    assign is_tab   = (i_char_code == CH_TAB);
    assign is_lf    = (i_char_code == CH_LF);
    assign ws       = (i_char_code == CH_SPACE) || is_tab || is_lf;
    assign nbsp     = (i_char_code == CH_NBSP);
    assign text_inc = (r_text == CNT_MAX) ? CNT_MAX : r_text + CNT_ONE;
    assign cont_inc = (r_cont == CNT_MAX) ? CNT_MAX : r_cont + CNT_ONE;
    assign text_ext = EXT_W'(r_text);
    assign cont_ext = EXT_W'(r_cont);
    assign text_rep = (text_ext > EXT_W'(REP_MAX)) ? REP_MAX : text_ext[REP_W-1:0];
    assign cont_rep = (cont_ext > EXT_W'(REP_MAX)) ? REP_MAX : cont_ext[REP_W-1:0];
    assign c_zero   = '0;

    // run update and result slots: close report, character, tail report
    always_comb begin
        n_open  = r_open;
        n_space = r_space;
        n_text  = r_text;
        n_cont  = r_cont;
        has_a   = 1'b0;
        has_b   = 1'b0;
        has_c   = 1'b0;
        a_space = 1'b0;
        emit_ch = i_char_code;
        res_c   = '0;
        res_c.kind        = KIND_REPORT;
        res_c.content_len = REP_W'(1);
        if (i_flush) begin
            has_a   = r_open;
            a_space = r_keep_ws ? 1'b0 : r_space;
            n_open  = 1'b0;
            n_space = 1'b0;
            n_text  = c_zero;
            n_cont  = c_zero;
        end else if (!r_keep_ws) begin
            if (r_open && (r_space == ws)) begin
                n_cont = cont_inc;
                if (!ws) begin
                    n_text  = text_inc;
                    has_b   = 1'b1;
                    emit_ch = nbsp ? CH_SPACE : i_char_code;
                end
            end else begin
                has_a   = r_open;
                a_space = r_space;
                n_open  = 1'b1;
                n_space = ws;
                n_text  = CNT_ONE;
                n_cont  = CNT_ONE;
                has_b   = 1'b1;
                emit_ch = (ws || nbsp) ? CH_SPACE : i_char_code;
            end
        end else begin
            n_space = 1'b0;
            if (is_tab || is_lf) begin
                has_a   = r_open;
                n_open  = 1'b0;
                n_text  = c_zero;
                n_cont  = c_zero;
                has_b   = is_tab;
                emit_ch = CH_TAB;
                has_c   = 1'b1;
                res_c.text_len = is_tab ? REP_W'(1) : REP_W'(0);
            end else begin
                n_open  = 1'b1;
                n_text  = text_inc;
                n_cont  = cont_inc;
                has_b   = 1'b1;
                emit_ch = nbsp ? CH_SPACE : i_char_code;
            end
        end
        n_wide = r_wide || (has_b && (emit_ch > MAX_NARROW));

        res_a             = '0;
        res_a.kind        = KIND_REPORT;
        res_a.text_len    = text_rep;
        res_a.content_len = cont_rep;
        res_a.is_space    = a_space;
        res_b             = '0;
        res_b.kind        = KIND_CHAR;
        res_b.ch          = emit_ch;
        res_a.wide        = n_wide;
        res_b.wide        = n_wide;
        res_c.wide        = n_wide;
    end

    // pack the present slots in order and mark the last one
    always_comb begin
        new_cnt = 2'(has_a) + 2'(has_b) + 2'(has_c);
        list[0] = has_a ? res_a : (has_b ? res_b : res_c);
        list[1] = has_a ? (has_b ? res_b : res_c) : res_c;
        list[2] = res_c;
        list[0].last = (new_cnt == 2'd1);
        list[1].last = (new_cnt == 2'd2);
        list[2].last = (new_cnt == 2'd3);
    end

    assign load = accept && (new_cnt != 2'd0);

    // load new results, else advance the queue on take
    always_comb begin
        n_res[0] = r_res[0];
        n_res[1] = r_res[1];
        n_res[2] = r_res[2];
        n_cnt    = r_cnt;
        if (load) begin
            n_res[0] = list[0];
            n_res[1] = list[1];
            n_res[2] = list[2];
            n_cnt    = new_cnt;
        end else if (take) begin
            n_res[0] = r_res[1];
            n_res[1] = r_res[2];
            n_cnt    = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_ws <= 1'b0;
            r_open    <= 1'b0;
            r_space   <= 1'b0;
            r_text    <= '0;
            r_cont    <= '0;
            r_wide    <= 1'b0;
            r_cnt     <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_keep_ws <= i_cfg_data;
            end
            if (accept) begin
                r_open  <= n_open;
                r_space <= n_space;
                r_text  <= n_text;
                r_cont  <= n_cont;
                r_wide  <= n_wide;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res[0] <= n_res[0];
        r_res[1] <= n_res[1];
        r_res[2] <= n_res[2];
    end

    assign o_out_kind        = r_res[0].kind;
    assign o_out_char        = r_res[0].ch;
    assign o_run_text_len    = r_res[0].text_len;
    assign o_run_content_len = r_res[0].content_len;
    assign o_run_is_space    = r_res[0].is_space;
    assign o_wide_seen       = r_res[0].wide;
    assign o_last            = r_res[0].last;

endmodule
